/* sv/pbpt_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// pbpt_pkg: shared types and constants of the pulse blanker
// Default parameter values, register layout, config and verdict structs.
// ----------------------------------------------------------------------------
package pbpt_pkg;

  // parameter defaults
  localparam int unsigned SAMPLE_BITS_DEF     = 16;
  localparam int unsigned WARMUP_FRAMES_DEF   = 10;
  localparam int unsigned POWER_FRAC_BITS_DEF = 15;

  // fixed widths
  localparam int unsigned POWER_W    = 48;  // running power, unsigned fixed point
  localparam int unsigned THR_W      = 16;  // threshold, unsigned 8.8
  localparam int unsigned THR_FRAC   = 8;   // fraction bits of the threshold
  localparam int unsigned WIN_W      = 5;
  localparam int unsigned CNT_W      = 32;
  localparam int unsigned WARM_W     = 4;
  localparam int unsigned PROD_W     = THR_W + POWER_W;
  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = 16;

  // register reset values and limits
  localparam logic [THR_W-1:0] THR_RESET  = 16'd2560;  // 10.0
  localparam logic [WIN_W-1:0] WIN_RESET  = 5'd10;
  localparam logic [WIN_W-1:0] WINDOW_MAX = 5'd20;

  // configuration register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_COMPLEX_MODE = 2'd0,
    CFG_THRESHOLD    = 2'd1,
    CFG_WINDOW_LOG2  = 2'd2
  } cfg_idx_e;

  typedef struct packed {
    logic             complex_mode;
    logic [THR_W-1:0] threshold;
    logic [WIN_W-1:0] window_log2;
  } cfg_t;

  // decision for one frame
  typedef struct packed {
    logic             hit;
    logic [CNT_W-1:0] total;
  } verdict_t;

endpackage
`default_nettype wire

/* sv/pbpt_power.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// pbpt_power: frame power
// Magnitude, square and sum of I (and Q in complex mode), scaled to the
// running-power fixed point format and saturated to its full scale.
// ----------------------------------------------------------------------------
module pbpt_power #(
  parameter int unsigned SAMPLE_BITS     = pbpt_pkg::SAMPLE_BITS_DEF,
  parameter int unsigned POWER_FRAC_BITS = pbpt_pkg::POWER_FRAC_BITS_DEF
) (
  input  wire logic signed [SAMPLE_BITS-1:0]        in_i_i,
  input  wire logic signed [SAMPLE_BITS-1:0]        in_q_i,
  input  wire logic                                 complex_mode_i,
  output logic             [pbpt_pkg::POWER_W-1:0]  power_o
);

  localparam int unsigned SQ_W  = 2 * SAMPLE_BITS;
  localparam int unsigned SUM_W = SQ_W + 1;

  logic [SAMPLE_BITS-1:0]       mag_i;
  logic [SAMPLE_BITS-1:0]       mag_q;
  logic [SQ_W-1:0]              sq_i;
  logic [SQ_W-1:0]              sq_q;
  logic [SUM_W-1:0]             sum;
  logic [pbpt_pkg::POWER_W-1:0] sum_ext;
  logic                         sat;

  // magnitudes; the most negative code maps to 2^(SAMPLE_BITS-1)
  always_comb begin
    mag_i = in_i_i[SAMPLE_BITS-1] ? (~$unsigned(in_i_i) + 1'b1) : $unsigned(in_i_i);
    mag_q = '0;
    if (complex_mode_i) begin
      mag_q = in_q_i[SAMPLE_BITS-1] ? (~$unsigned(in_q_i) + 1'b1) : $unsigned(in_q_i);
    end
  end

  // squares and sum
  assign sq_i = SQ_W'(mag_i) * SQ_W'(mag_i);
  assign sq_q = SQ_W'(mag_q) * SQ_W'(mag_q);
  assign sum  = SUM_W'(sq_i) + SUM_W'(sq_q);

  // scale to fixed point, saturate when the integer part overflows
  assign sat     = |(sum >> (pbpt_pkg::POWER_W - POWER_FRAC_BITS));
  assign sum_ext = pbpt_pkg::POWER_W'(sum);
  assign power_o = sat ? '1 : (sum_ext << POWER_FRAC_BITS);

endmodule
`default_nettype wire

/* sv/pbpt_tracker.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// pbpt_tracker: running power, blank decision and blank counter
// Holds the running-power state, decides per frame and updates on update_i.
// ----------------------------------------------------------------------------
module pbpt_tracker #(
  parameter int unsigned WARMUP_FRAMES = pbpt_pkg::WARMUP_FRAMES_DEF
) (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire pbpt_pkg::cfg_t                cfg_i,
  input  wire logic [pbpt_pkg::POWER_W-1:0]  power_i,
  input  wire logic                          update_i,
  output pbpt_pkg::verdict_t                 verdict_o
);

  localparam int unsigned PW = pbpt_pkg::POWER_W;
  localparam int unsigned WW = pbpt_pkg::WARM_W;
  localparam int unsigned CW = pbpt_pkg::CNT_W;
  localparam int unsigned XW = pbpt_pkg::PROD_W;

  logic [PW-1:0]                 rp_q, rp_d, rp_cur;
  logic [WW-1:0]                 warm_q, warm_d;
  logic [CW-1:0]                 cnt_q, cnt_d;
  logic                          warming;
  logic [pbpt_pkg::WIN_W-1:0]    win;
  logic [XW-1:0]                 lhs, rhs;
  logic [PW-1:0]                 diff;
  logic                          rising;
  logic                          hit;

  // during warm-up the running power is loaded with the frame power
  assign warming = (warm_q < WW'(WARMUP_FRAMES));
  assign rp_cur  = warming ? power_i : rp_q;
  assign warm_d  = warming ? (warm_q + 1'b1) : warm_q;

  // blank test: power * 256 > threshold * running power
  assign lhs = XW'({power_i, {pbpt_pkg::THR_FRAC{1'b0}}});
  assign rhs = XW'(cfg_i.threshold) * XW'(rp_cur);
  assign hit = (cfg_i.threshold != '0) && (rp_cur != '0) && (lhs > rhs);

  // exponential average, window clamped
  assign win    = (cfg_i.window_log2 > pbpt_pkg::WINDOW_MAX) ? pbpt_pkg::WINDOW_MAX
                                                             : cfg_i.window_log2;
  assign rising = (power_i >= rp_cur);
  assign diff   = rising ? (power_i - rp_cur) : (rp_cur - power_i);

  always_comb begin
    if (hit) begin
      rp_d = rp_cur;
    end else if (rising) begin
      rp_d = rp_cur + (diff >> win);
    end else begin
      rp_d = rp_cur - (diff >> win);
    end
  end

  // saturating blank counter
  assign cnt_d = (hit && (cnt_q != '1)) ? (cnt_q + 1'b1) : cnt_q;

  assign verdict_o.hit   = hit;
  assign verdict_o.total = cnt_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rp_q   <= '0;
      warm_q <= '0;
      cnt_q  <= '0;
    end else if (update_i) begin
      rp_q   <= rp_d;
      warm_q <= warm_d;
      cnt_q  <= cnt_d;
    end
  end

endmodule
`default_nettype wire

/* sv/pulse_blanker_power_threshold.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// pulse_blanker_power_threshold: impulse blanker with running-power threshold
//
// Input stream carries one real sample or one I/Q frame per transfer; the
// output stream carries the frame, zeroed when its power exceeds threshold
// times the running power, with a blanked flag and the saturating count of
// blanked frames. Registers are written through cfg_we_i / cfg_idx_i /
// cfg_data_i; the user must write them only while the stream is idle,
// which the block itself does not enforce. Three register stages, in order:
// input, frame power, result. Throughput is one frame per clock while
// m_axis_tready is high. The running-power loop closes inside
// the result stage: one 16x48 multiply, a compare and the average update.
// Each stage moves when its successor is empty or moving, so s_axis_tready
// stays high while the output waits, until all three stages hold a frame.
// Reset clears the stage valid bits, running power, warm-up and blank
// counters and loads the register defaults (real mode, threshold 10.0,
// window 2^10).
// ----------------------------------------------------------------------------
module pulse_blanker_power_threshold #(
  parameter  int unsigned SAMPLE_BITS     = pbpt_pkg::SAMPLE_BITS_DEF,
  parameter  int unsigned WARMUP_FRAMES   = pbpt_pkg::WARMUP_FRAMES_DEF,
  parameter  int unsigned POWER_FRAC_BITS = pbpt_pkg::POWER_FRAC_BITS_DEF,
  localparam int unsigned IN_DATA_W       = ((2 * SAMPLE_BITS + 7) / 8) * 8,
  localparam int unsigned OUT_DATA_W      = ((2 * SAMPLE_BITS + pbpt_pkg::CNT_W + 7) / 8) * 8
) (
  input  wire logic                              clk_i,
  input  wire logic                              rst_ni,
  // configuration writes
  input  wire logic                              cfg_we_i,
  input  wire logic [pbpt_pkg::CFG_IDX_W-1:0]    cfg_idx_i,
  input  wire logic [pbpt_pkg::CFG_DATA_W-1:0]   cfg_data_i,
  // input stream
  input  wire logic                              s_axis_tvalid,
  output logic                                   s_axis_tready,
  input  wire logic [IN_DATA_W-1:0]              s_axis_tdata,   // in_i, in_q
  // output stream
  output logic                                   m_axis_tvalid,
  input  wire logic                              m_axis_tready,
  output logic      [OUT_DATA_W-1:0]             m_axis_tdata,   // out_i, out_q, blank_total
  output logic                                   m_axis_tuser    // blanked
);

  localparam int unsigned SB = SAMPLE_BITS;

  pbpt_pkg::cfg_t                 cfg_q;
  pbpt_pkg::verdict_t             verdict;

  logic                           v1_q, v2_q, v3_q;
  logic                           adv1, adv2, adv3;
  logic signed [SB-1:0]           s1_i_q, s1_q_q;
  logic signed [SB-1:0]           s2_i_q, s2_q_q;
  logic [pbpt_pkg::POWER_W-1:0]   s2_pow_q;
  logic [pbpt_pkg::POWER_W-1:0]   power;
  logic signed [SB-1:0]           out_i_q, out_q_q;
  logic                           blanked_q;
  logic [pbpt_pkg::CNT_W-1:0]     total_q;
  logic                           update;

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.complex_mode <= 1'b0;
      cfg_q.threshold    <= pbpt_pkg::THR_RESET;
      cfg_q.window_log2  <= pbpt_pkg::WIN_RESET;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        pbpt_pkg::CFG_COMPLEX_MODE: cfg_q.complex_mode <= cfg_data_i[0];
        pbpt_pkg::CFG_THRESHOLD:    cfg_q.threshold    <= cfg_data_i[pbpt_pkg::THR_W-1:0];
        pbpt_pkg::CFG_WINDOW_LOG2:  cfg_q.window_log2  <= cfg_data_i[pbpt_pkg::WIN_W-1:0];
        default: ;
      endcase
    end
  end

  // stage advance: a stage loads when it is empty or its content moves on
  assign adv3   = !v3_q || m_axis_tready;
  assign adv2   = !v2_q || adv3;
  assign adv1   = !v1_q || adv2;
  assign update = v2_q && adv3;

  assign s_axis_tready = adv1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
    end else begin
      if (adv1) v1_q <= s_axis_tvalid;
      if (adv2) v2_q <= v1_q;
      if (adv3) v3_q <= v2_q;
    end
  end

  // input stage
  always_ff @(posedge clk_i) begin
    if (adv1 && s_axis_tvalid) begin
      s1_i_q <= s_axis_tdata[SB-1:0];
      s1_q_q <= s_axis_tdata[2*SB-1:SB];
    end
  end

  // power stage
  pbpt_power #(
    .SAMPLE_BITS     (SAMPLE_BITS),
    .POWER_FRAC_BITS (POWER_FRAC_BITS)
  ) u_power (
    .in_i_i         (s1_i_q),
    .in_q_i         (s1_q_q),
    .complex_mode_i (cfg_q.complex_mode),
    .power_o        (power)
  );

  always_ff @(posedge clk_i) begin
    if (adv2 && v1_q) begin
      s2_i_q   <= s1_i_q;
      s2_q_q   <= cfg_q.complex_mode ? s1_q_q : '0;
      s2_pow_q <= power;
    end
  end

  // decision stage with the running-power state
  pbpt_tracker #(
    .WARMUP_FRAMES (WARMUP_FRAMES)
  ) u_tracker (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .cfg_i     (cfg_q),
    .power_i   (s2_pow_q),
    .update_i  (update),
    .verdict_o (verdict)
  );

  // result register
  always_ff @(posedge clk_i) begin
    if (update) begin
      out_i_q   <= verdict.hit ? '0 : s2_i_q;
      out_q_q   <= verdict.hit ? '0 : s2_q_q;
      blanked_q <= verdict.hit;
      total_q   <= verdict.total;
    end
  end

  assign m_axis_tvalid = v3_q;
  assign m_axis_tdata  = OUT_DATA_W'({total_q, out_q_q, out_i_q});
  assign m_axis_tuser  = blanked_q;

endmodule
`default_nettype wire

/* sv/pbpt_checker.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// pbpt_checker: port-level checks for the pulse blanker
// Watches the stream ports of the top level; bound to it below.
// ----------------------------------------------------------------------------
module pbpt_checker #(
  parameter  int unsigned SAMPLE_BITS = pbpt_pkg::SAMPLE_BITS_DEF,
  localparam int unsigned OUT_DATA_W  = ((2 * SAMPLE_BITS + pbpt_pkg::CNT_W + 7) / 8) * 8
) (
  input wire logic                  clk_i,
  input wire logic                  rst_ni,
  input wire logic                  s_axis_tready,
  input wire logic                  m_axis_tvalid,
  input wire logic                  m_axis_tready,
  input wire logic [OUT_DATA_W-1:0] m_axis_tdata,
  input wire logic                  m_axis_tuser
);

  // a waiting result stays offered
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid)
    else $error("output valid dropped while stalled");

  // a stalled result keeps its payload
  a_out_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> $stable(m_axis_tdata) && $stable(m_axis_tuser))
    else $error("output payload changed while stalled");

  // blanked frames carry zero samples
  a_blank_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tuser |-> m_axis_tdata[2*SAMPLE_BITS-1:0] == '0)
    else $error("blanked frame with nonzero samples");

  // with the result register empty the input side must be open
  a_ready_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !m_axis_tvalid |-> s_axis_tready)
    else $error("input stalled with empty output");

  // a blanked frame never shows a zero blank count
  a_count_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tuser
      |-> m_axis_tdata[2*SAMPLE_BITS+pbpt_pkg::CNT_W-1:2*SAMPLE_BITS] != '0)
    else $error("blanked frame with zero blank count");

endmodule

bind pulse_blanker_power_threshold pbpt_checker #(
  .SAMPLE_BITS (SAMPLE_BITS)
) u_pbpt_checker (.*);
`default_nettype wire
